// ===== rtl/core/pcm_pkg.sv =====
// Shared constants, command and status types for the covariance matrix block.
package pcm_pkg;

   localparam int MAX_DIMS    = 8;
   localparam int MAX_RECORDS = 256;
   localparam int DIM_W       = $clog2(MAX_DIMS);
   localparam int REC_W       = $clog2(MAX_RECORDS);
   localparam int CNT_W       = REC_W + 1;
   localparam int CFG_W       = 4;
   localparam int SMP_W       = 32;
   localparam int ACC_W       = 80;
   localparam int COV_W       = 64;
   localparam int STORE_DEPTH = MAX_RECORDS * MAX_DIMS;
   localparam int ADDR_W      = REC_W + DIM_W;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLR,
      OP_READ,
      OP_SUM,
      OP_RDA,
      OP_RDB,
      OP_DEV,
      OP_MUL,
      OP_ACC,
      OP_ABS,
      OP_DIV,
      OP_MEAN,
      OP_COV,
      OP_FIN
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               load;
      logic [REC_W-1:0]   rec;
      logic [DIM_W-1:0]   dim;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]   n_records;
      logic               n_zero;
      logic [CFG_W-1:0]   dims;
      logic               div_busy;
   } sts_type;

endpackage

// ===== rtl/core/pcm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pcm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pcm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module pcm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pcm_pkg::ACC_W-1:0] dividend,
   input  logic [pcm_pkg::CNT_W-1:0] divisor,
   output logic                      busy,
   output logic [pcm_pkg::ACC_W-1:0] quotient
);

   localparam int STEP_W = $clog2(pcm_pkg::ACC_W + 1);

   logic [pcm_pkg::ACC_W-1:0] quo_ff, quo_in;
   logic [pcm_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [pcm_pkg::CNT_W-1:0] div_ff;
   logic [STEP_W-1:0]         cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic [pcm_pkg::CNT_W:0]   shifted;
   logic                      fits;

   // load on start, else shift in one dividend bit and try a subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[pcm_pkg::ACC_W-1]};
      fits    = shifted >= {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = STEP_W'(pcm_pkg::ACC_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[pcm_pkg::ACC_W-2:0], fits};
         rem_in  = fits ? pcm_pkg::CNT_W'(shifted - {1'b0, div_ff})
                        : shifted[pcm_pkg::CNT_W-1:0];
         cnt_in  = cnt_ff - STEP_W'(1);
         busy_in = cnt_ff != STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/pcm_datapath.sv =====
// Datapath: sample store, load counters, accumulator, multiplier and divider.
module pcm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcm_pkg::CFG_W-1:0]         csr_dims_in_use,
   input  logic signed [pcm_pkg::SMP_W-1:0]  req_sample_value,
   input  pcm_pkg::cmd_type                  cmd,
   output pcm_pkg::sts_type                  sts,
   output logic signed [pcm_pkg::COV_W-1:0]  rsp_covariance,
   output logic                              rsp_items_dropped
);

   localparam int SW = pcm_pkg::SMP_W;
   localparam int AW = pcm_pkg::ACC_W;
   localparam int CW = pcm_pkg::COV_W;

   logic [pcm_pkg::CFG_W-1:0]   dims_ff;
   logic [pcm_pkg::CFG_W-1:0]   eff_dims;
   logic [pcm_pkg::CNT_W-1:0]   rec_cnt_ff;
   logic [pcm_pkg::DIM_W-1:0]   pos_ff;
   logic                        drop_ff;
   logic                        full;
   logic [pcm_pkg::DIM_W:0]     pos_next;
   logic                        wr_en;
   logic [pcm_pkg::ADDR_W-1:0]  wr_addr;
   logic [pcm_pkg::ADDR_W-1:0]  rd_addr;
   logic [SW-1:0]               rd_data;

   logic [SW-1:0]               means_ff [pcm_pkg::MAX_DIMS];
   logic [SW-1:0]               mean_a_ff;
   logic [SW-1:0]               x_a_ff;
   logic [SW-1:0]               mag_a_ff, mag_b_ff;
   logic                        neg_a_ff, neg_b_ff;
   logic [2*SW-1:0]             prod_ff;
   logic                        prod_neg_ff;
   logic [AW-1:0]               acc_ff;
   logic [AW-1:0]               dvd_ff;
   logic                        neg_ff;
   logic [CW-1:0]               cov_ff;
   logic [AW-1:0]               quo;
   logic                        div_busy;

   logic [SW-1:0]               mean_b;
   logic                        ge_a, ge_b;
   logic                        pos_over, neg_over;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= pcm_pkg::CFG_W'(1);
      end else if (csr_valid) begin
         dims_ff <= csr_dims_in_use;
      end
   end

   // clamp width to the supported range
   always_comb begin
      if (dims_ff == '0) begin
         eff_dims = pcm_pkg::CFG_W'(1);
      end else if (dims_ff > pcm_pkg::CFG_W'(pcm_pkg::MAX_DIMS)) begin
         eff_dims = pcm_pkg::CFG_W'(pcm_pkg::MAX_DIMS);
      end else begin
         eff_dims = dims_ff;
      end
   end

   // load counters
   assign full     = rec_cnt_ff == pcm_pkg::CNT_W'(pcm_pkg::MAX_RECORDS);
   assign pos_next = {1'b0, pos_ff} + (pcm_pkg::DIM_W+1)'(1);
   assign wr_en    = cmd.load && !full;
   assign wr_addr  = {rec_cnt_ff[pcm_pkg::REC_W-1:0], pos_ff};
   assign rd_addr  = {cmd.rec, cmd.dim};

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_cnt_ff <= '0;
         pos_ff     <= '0;
         drop_ff    <= 1'b0;
      end else if (cmd.op == pcm_pkg::OP_FIN) begin
         rec_cnt_ff <= '0;
         pos_ff     <= '0;
         drop_ff    <= 1'b0;
      end else if (cmd.load) begin
         if (full) begin
            drop_ff <= 1'b1;
         end else if (pcm_pkg::CFG_W'(pos_next) >= eff_dims) begin
            pos_ff     <= '0;
            rec_cnt_ff <= rec_cnt_ff + pcm_pkg::CNT_W'(1);
         end else begin
            pos_ff <= pos_next[pcm_pkg::DIM_W-1:0];
         end
      end
   end

   pcm_ram #(
      .WIDTH (SW),
      .DEPTH (pcm_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == pcm_pkg::OP_DIV),
      .dividend (dvd_ff),
      .divisor  (rec_cnt_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   // deviation magnitudes by compare and subtract
   assign mean_b   = means_ff[cmd.dim];
   assign ge_a     = $signed(x_a_ff) >= $signed(mean_a_ff);
   assign ge_b     = $signed(rd_data) >= $signed(mean_b);
   assign pos_over = |quo[AW-1:CW-1];
   assign neg_over = (|quo[AW-1:CW]) || (quo[CW-1] && (|quo[CW-2:0]));

   // sequence the arithmetic by command
   always_ff @(posedge clock) begin
      case (cmd.op)
         pcm_pkg::OP_CLR: begin
            acc_ff <= '0;
            cov_ff <= '0;
         end
         pcm_pkg::OP_SUM: begin
            acc_ff <= acc_ff + {{(AW-SW){rd_data[SW-1]}}, rd_data};
         end
         pcm_pkg::OP_RDA: begin
            mean_a_ff <= means_ff[cmd.dim];
         end
         pcm_pkg::OP_RDB: begin
            x_a_ff <= rd_data;
         end
         pcm_pkg::OP_DEV: begin
            mag_a_ff <= ge_a ? x_a_ff - mean_a_ff : mean_a_ff - x_a_ff;
            neg_a_ff <= !ge_a;
            mag_b_ff <= ge_b ? rd_data - mean_b : mean_b - rd_data;
            neg_b_ff <= !ge_b;
         end
         pcm_pkg::OP_MUL: begin
            prod_ff     <= (2*SW)'(mag_a_ff) * (2*SW)'(mag_b_ff);
            prod_neg_ff <= neg_a_ff ^ neg_b_ff;
         end
         pcm_pkg::OP_ACC: begin
            if (prod_neg_ff) begin
               acc_ff <= acc_ff - {{(AW-2*SW){1'b0}}, prod_ff};
            end else begin
               acc_ff <= acc_ff + {{(AW-2*SW){1'b0}}, prod_ff};
            end
         end
         pcm_pkg::OP_ABS: begin
            dvd_ff <= acc_ff[AW-1] ? AW'(0) - acc_ff : acc_ff;
            neg_ff <= acc_ff[AW-1];
         end
         pcm_pkg::OP_MEAN: begin
            means_ff[cmd.dim] <= neg_ff ? SW'(0) - quo[SW-1:0] : quo[SW-1:0];
            acc_ff            <= '0;
         end
         pcm_pkg::OP_COV: begin
            acc_ff <= '0;
            if (neg_ff) begin
               cov_ff <= neg_over ? {1'b1, {(CW-1){1'b0}}} : CW'(0) - quo[CW-1:0];
            end else begin
               cov_ff <= pos_over ? {1'b0, {(CW-1){1'b1}}} : quo[CW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign sts.n_records     = rec_cnt_ff;
   assign sts.n_zero        = rec_cnt_ff == '0;
   assign sts.dims          = eff_dims;
   assign sts.div_busy      = div_busy;
   assign rsp_covariance    = cov_ff;
   assign rsp_items_dropped = drop_ff;

   assert property (@(posedge clock) disable iff (reset)
      rec_cnt_ff <= pcm_pkg::CNT_W'(pcm_pkg::MAX_RECORDS))
      else $error("record count beyond store capacity");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load && full |=> drop_ff)
      else $error("drop flag missed on a full store");

   assert property (@(posedge clock) disable iff (reset)
      cmd.op == pcm_pkg::OP_DIV |=> div_busy)
      else $error("divider did not start");

endmodule

// ===== rtl/core/pcm_ctrl.sv =====
// Controller: load handshake, mean and covariance loops, result handshake.
module pcm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_last_record,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pcm_pkg::DIM_W-1:0]   rsp_row_index,
   output logic [pcm_pkg::DIM_W-1:0]   rsp_col_index,
   output logic                        rsp_last_entry,
   input  pcm_pkg::sts_type            sts,
   output pcm_pkg::cmd_type            cmd
);

   typedef enum logic [4:0] {
      S_LOAD, S_START,
      S_M_RD, S_M_SUM, S_M_ABS, S_M_GO, S_M_WAIT, S_M_WR,
      S_C_RDA, S_C_RDB, S_C_DEV, S_C_MUL, S_C_ACC,
      S_C_ABS, S_C_GO, S_C_WAIT, S_C_WR, S_OUT
   } state_type;

   state_type                   state_ff, state_in;
   logic [pcm_pkg::CNT_W-1:0]   rec_ff, rec_in;
   logic [pcm_pkg::DIM_W-1:0]   row_ff, row_in;
   logic [pcm_pkg::DIM_W-1:0]   col_ff, col_in;
   logic [pcm_pkg::CFG_W-1:0]   last_dim;
   logic                        rec_last, row_last, col_last;

   assign last_dim = sts.dims - pcm_pkg::CFG_W'(1);
   assign rec_last = (rec_ff + pcm_pkg::CNT_W'(1)) == sts.n_records;
   assign row_last = pcm_pkg::CFG_W'(row_ff) == last_dim;
   assign col_last = pcm_pkg::CFG_W'(col_ff) == last_dim;

   // next state, loop counters and command
   always_comb begin
      state_in = state_ff;
      rec_in   = rec_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      cmd.op   = pcm_pkg::OP_NONE;
      cmd.load = 1'b0;
      cmd.rec  = rec_ff[pcm_pkg::REC_W-1:0];
      cmd.dim  = row_ff;
      unique case (state_ff)
         S_LOAD: begin
            cmd.load = req_valid;
            if (req_valid && req_last_record) begin
               state_in = S_START;
               rec_in   = '0;
               row_in   = '0;
               col_in   = '0;
            end
         end
         S_START: begin
            cmd.op   = pcm_pkg::OP_CLR;
            state_in = sts.n_zero ? S_OUT : S_M_RD;
         end
         S_M_RD: begin
            cmd.op   = pcm_pkg::OP_READ;
            state_in = S_M_SUM;
         end
         S_M_SUM: begin
            cmd.op = pcm_pkg::OP_SUM;
            if (rec_last) begin
               rec_in   = '0;
               state_in = S_M_ABS;
            end else begin
               rec_in   = rec_ff + pcm_pkg::CNT_W'(1);
               state_in = S_M_RD;
            end
         end
         S_M_ABS: begin
            cmd.op   = pcm_pkg::OP_ABS;
            state_in = S_M_GO;
         end
         S_M_GO: begin
            cmd.op   = pcm_pkg::OP_DIV;
            state_in = S_M_WAIT;
         end
         S_M_WAIT: begin
            if (!sts.div_busy) begin
               state_in = S_M_WR;
            end
         end
         S_M_WR: begin
            cmd.op = pcm_pkg::OP_MEAN;
            if (row_last) begin
               row_in   = '0;
               state_in = S_C_RDA;
            end else begin
               row_in   = row_ff + pcm_pkg::DIM_W'(1);
               state_in = S_M_RD;
            end
         end
         S_C_RDA: begin
            cmd.op   = pcm_pkg::OP_RDA;
            state_in = S_C_RDB;
         end
         S_C_RDB: begin
            cmd.op   = pcm_pkg::OP_RDB;
            cmd.dim  = col_ff;
            state_in = S_C_DEV;
         end
         S_C_DEV: begin
            cmd.op   = pcm_pkg::OP_DEV;
            cmd.dim  = col_ff;
            state_in = S_C_MUL;
         end
         S_C_MUL: begin
            cmd.op   = pcm_pkg::OP_MUL;
            state_in = S_C_ACC;
         end
         S_C_ACC: begin
            cmd.op = pcm_pkg::OP_ACC;
            if (rec_last) begin
               rec_in   = '0;
               state_in = S_C_ABS;
            end else begin
               rec_in   = rec_ff + pcm_pkg::CNT_W'(1);
               state_in = S_C_RDA;
            end
         end
         S_C_ABS: begin
            cmd.op   = pcm_pkg::OP_ABS;
            state_in = S_C_GO;
         end
         S_C_GO: begin
            cmd.op   = pcm_pkg::OP_DIV;
            state_in = S_C_WAIT;
         end
         S_C_WAIT: begin
            if (!sts.div_busy) begin
               state_in = S_C_WR;
            end
         end
         S_C_WR: begin
            cmd.op   = pcm_pkg::OP_COV;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (row_last && col_last) begin
                  cmd.op   = pcm_pkg::OP_FIN;
                  state_in = S_LOAD;
               end else begin
                  if (col_last) begin
                     col_in = '0;
                     row_in = row_ff + pcm_pkg::DIM_W'(1);
                  end else begin
                     col_in = col_ff + pcm_pkg::DIM_W'(1);
                  end
                  state_in = sts.n_zero ? S_OUT : S_C_RDA;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // hold state and loop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         rec_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rec_ff   <= rec_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   assign req_stall      = state_ff != S_LOAD;
   assign rsp_valid      = state_ff == S_OUT;
   assign rsp_row_index  = row_ff;
   assign rsp_col_index  = col_ff;
   assign rsp_last_entry = row_last && col_last;

   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input taken while a result is shown");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |-> !sts.div_busy)
      else $error("divider busy while loading");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_C_ACC |-> rec_ff < sts.n_records)
      else $error("record loop ran past the record count");

endmodule

// ===== rtl/core/population_covariance_matrix_top.sv =====
// Top level of the population covariance matrix block.
// Loading: one sample per cycle, no stall while loading.
// After the last sample: a start state, then the means one dimension at a time,
// then one matrix entry at a time (d*d entries), each paced by the single store
// read port and the divider.
// With no complete record, d*d zero entries follow at one per cycle while the output is not stalled.
// Reset is synchronous: counters and flags clear, dims_in_use returns to 1, store kept.
module population_covariance_matrix_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcm_pkg::CFG_W-1:0]         csr_dims_in_use,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [pcm_pkg::SMP_W-1:0]  req_sample_value,
   input  logic                              req_last_record,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pcm_pkg::DIM_W-1:0]         rsp_row_index,
   output logic [pcm_pkg::DIM_W-1:0]         rsp_col_index,
   output logic signed [pcm_pkg::COV_W-1:0]  rsp_covariance,
   output logic                              rsp_items_dropped,
   output logic                              rsp_last_entry
);

   pcm_pkg::cmd_type cmd;
   pcm_pkg::sts_type sts;

   // sequencing
   pcm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_record (req_last_record),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_index   (rsp_col_index),
      .rsp_last_entry  (rsp_last_entry),
      .sts             (sts),
      .cmd             (cmd)
   );

   // storage and arithmetic
   pcm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_dims_in_use   (csr_dims_in_use),
      .req_sample_value  (req_sample_value),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_covariance    (rsp_covariance),
      .rsp_items_dropped (rsp_items_dropped)
   );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the population covariance matrix block.
module testbench;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 100;
   localparam logic signed [127:0] COV_HI = 128'sh7fff_ffff_ffff_ffff;
   localparam logic signed [127:0] COV_LO = -COV_HI - 1;

   typedef struct {
      logic [pcm_pkg::DIM_W-1:0]        row;
      logic [pcm_pkg::DIM_W-1:0]        col;
      logic signed [pcm_pkg::COV_W-1:0] cov;
      logic                             dropped;
      logic                             last_e;
   } matrix_entry_type;

   // one directed step: a width write or one sample, with an optional typed-in covariance
   typedef struct {
      bit                               is_cfg;
      logic [pcm_pkg::CFG_W-1:0]        dims;
      logic signed [pcm_pkg::SMP_W-1:0] value;
      bit                               last;
      bit                               known;
      longint                           cov;
   } step_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [pcm_pkg::CFG_W-1:0]        csr_dims_in_use = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic signed [pcm_pkg::SMP_W-1:0] req_sample_value = '0;
   logic                             req_last_record = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [pcm_pkg::DIM_W-1:0]        rsp_row_index;
   logic [pcm_pkg::DIM_W-1:0]        rsp_col_index;
   logic signed [pcm_pkg::COV_W-1:0] rsp_covariance;
   logic                             rsp_items_dropped;
   logic                             rsp_last_entry;

   matrix_entry_type          expected_entries[$];
   logic [pcm_pkg::SMP_W-1:0] sample_mem[pcm_pkg::STORE_DEPTH];
   int                        stored_records;
   int                        record_pos;
   bit                        drop_seen;
   logic [pcm_pkg::CFG_W-1:0] width_reg;
   int                        fail_count;
   int                        samples_sent;
   int                        idle_cycles;
   bit                        quiet;

   population_covariance_matrix_top dut (.*);

   always #4 clock = ~clock;

   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > pcm_pkg::MAX_DIMS) return pcm_pkg::MAX_DIMS;
      return int'(width_reg);
   endfunction

   // store one sample; on the final one compute the matrix and queue its entries
   function automatic void predict_matrix(logic [pcm_pkg::SMP_W-1:0] value, bit last,
                                          bit known, longint known_cov);
      int            d;
      int            n;
      longint        sum;
      longint        means[pcm_pkg::MAX_DIMS];
      longint        di, dj;
      logic signed [127:0] da, db, acc, nn, q;
      logic signed [pcm_pkg::COV_W-1:0] cov[pcm_pkg::MAX_DIMS][pcm_pkg::MAX_DIMS];
      matrix_entry_type e;
      d = active_width();
      if (stored_records < pcm_pkg::MAX_RECORDS) begin
         sample_mem[stored_records * pcm_pkg::MAX_DIMS + record_pos] = value;
         record_pos++;
         if (record_pos >= d) begin
            record_pos = 0;
            stored_records++;
         end
      end else begin
         drop_seen = 1'b1;
      end
      if (!last) return;
      n = stored_records;
      for (int i = 0; i < d; i++) begin
         sum = 0;
         for (int r = 0; r < n; r++)
            sum += longint'($signed(sample_mem[r * pcm_pkg::MAX_DIMS + i]));
         means[i] = (n != 0) ? sum / n : 0;
      end
      nn = 128'(n);
      for (int i = 0; i < d; i++) begin
         for (int j = i; j < d; j++) begin
            acc = 0;
            for (int r = 0; r < n; r++) begin
               di = longint'($signed(sample_mem[r * pcm_pkg::MAX_DIMS + i])) - means[i];
               dj = longint'($signed(sample_mem[r * pcm_pkg::MAX_DIMS + j])) - means[j];
               da = 128'(di);
               db = 128'(dj);
               acc += da * db;
            end
            q = (n != 0) ? acc / nn : 0;
            if (q > COV_HI) q = COV_HI;
            if (q < COV_LO) q = COV_LO;
            cov[i][j] = q[63:0];
            cov[j][i] = q[63:0];
         end
      end
      for (int i = 0; i < d; i++) begin
         for (int j = 0; j < d; j++) begin
            e.row     = pcm_pkg::DIM_W'(i);
            e.col     = pcm_pkg::DIM_W'(j);
            e.cov     = known ? known_cov : cov[i][j];
            e.dropped = drop_seen;
            e.last_e  = (i == d - 1) && (j == d - 1);
            expected_entries.push_back(e);
         end
      end
      stored_records = 0;
      record_pos     = 0;
      drop_seen      = 1'b0;
   endfunction

   // present one sample, idling first at random; returns at the accepting edge
   task automatic send_sample(logic signed [pcm_pkg::SMP_W-1:0] value, bit last, bit known,
                              longint known_cov);
      if (!quiet && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 33);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      req_last_record  <= last;
      do @(posedge clock); while (req_stall);
      predict_matrix(value, last, known, known_cov);
      samples_sent++;
   endtask

   // let all results drain, then give the block time to settle before a write
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_width(logic [pcm_pkg::CFG_W-1:0] value);
      wait_idle();
      csr_valid       <= 1'b1;
      csr_dims_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      width_reg = value;
   endtask

   function automatic logic signed [pcm_pkg::SMP_W-1:0] pick_value(
         logic signed [pcm_pkg::SMP_W-1:0] base);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
         2: return $signed($urandom_range(0, 2000)) - 1000;
         default: return base + $signed($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // drive the result stall at random outside the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 33);
   end

   // compare each result transfer with the oldest expected entry
   always @(posedge clock) begin
      matrix_entry_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_entries.size() == 0) begin
            $error("unexpected result transfer row %0d col %0d", rsp_row_index, rsp_col_index);
            fail_count++;
         end else begin
            e = expected_entries.pop_front();
            if (rsp_row_index !== e.row) begin
               $error("row_index expected %0d actual %0d", e.row, rsp_row_index);
               fail_count++;
            end
            if (rsp_col_index !== e.col) begin
               $error("col_index expected %0d actual %0d", e.col, rsp_col_index);
               fail_count++;
            end
            if (rsp_covariance !== e.cov) begin
               $error("covariance expected %0d actual %0d", e.cov, rsp_covariance);
               fail_count++;
            end
            if (rsp_items_dropped !== e.dropped) begin
               $error("items_dropped expected %0d actual %0d", e.dropped, rsp_items_dropped);
               fail_count++;
            end
            if (rsp_last_entry !== e.last_e) begin
               $error("last_entry expected %0d actual %0d", e.last_e, rsp_last_entry);
               fail_count++;
            end
         end
      end
   end

   // end the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   step_type directed_steps[] = '{
      '{1, 4'd1,  0,             0, 0, 0},
      '{0, 4'd0,  32'sh7fffffff, 1, 1, 0},   // one record: zero spread
      '{1, 4'd0,  0,             0, 0, 0},   // width zero acts as one
      '{0, 4'd0,  32'sh80000000, 1, 1, 0},
      '{1, 4'd2,  0,             0, 0, 0},
      '{0, 4'd0,  5,             1, 1, 0},   // unfinished record only: empty set
      '{1, 4'd15, 0,             0, 0, 0},   // width above range acts as eight
      '{0, 4'd0,  -1,            1, 1, 0},
      '{1, 4'd2,  0,             0, 0, 0},
      '{0, 4'd0,  32'sh7fffffff, 0, 0, 0},
      '{0, 4'd0,  32'sh80000000, 0, 0, 0},
      '{0, 4'd0,  32'sh80000000, 0, 0, 0},
      '{0, 4'd0,  32'sh7fffffff, 1, 0, 0},
      '{1, 4'd3,  0,             0, 0, 0},
      '{0, 4'd0,  1,             0, 0, 0},
      '{0, 4'd0,  -1,            0, 0, 0},
      '{0, 4'd0,  65536,         0, 0, 0},
      '{0, 4'd0,  0,             0, 0, 0},
      '{0, 4'd0,  7,             0, 0, 0},
      '{0, 4'd0,  -3,            0, 0, 0},
      '{0, 4'd0,  32'sh7fffffff, 0, 0, 0},
      '{0, 4'd0,  0,             0, 0, 0},
      '{0, 4'd0,  32'sh80000000, 0, 0, 0},
      '{0, 4'd0,  12345,         1, 0, 0}    // trailing partial record dropped
   };

   initial begin
      int                               set_index;
      int                               d;
      int                               n_items;
      logic signed [pcm_pkg::SMP_W-1:0] base;
      stored_records = 0;
      record_pos     = 0;
      drop_seen      = 1'b0;
      width_reg      = pcm_pkg::CFG_W'(1);
      fail_count     = 0;
      samples_sent   = 0;
      quiet          = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (directed_steps[k]) begin
         if (directed_steps[k].is_cfg)
            write_width(directed_steps[k].dims);
         else
            send_sample(directed_steps[k].value, directed_steps[k].last,
                        directed_steps[k].known, directed_steps[k].cov);
      end

      // random data sets; the third overfills the store, the fifth to seventh (if reached) run without idling
      set_index = 0;
      while (samples_sent < 320) begin
         quiet = (set_index >= 4) && (set_index < 7);
         if (set_index == 2) begin
            write_width(pcm_pkg::CFG_W'(1));
            n_items = pcm_pkg::MAX_RECORDS + $urandom_range(1, 4);
         end else begin
            if (set_index == 0 || $urandom_range(0, 1) != 0)
               write_width(pcm_pkg::CFG_W'($urandom_range(0, 15)));
            d = active_width();
            n_items = $urandom_range(0, 4) * d;
            if ($urandom_range(0, 3) == 0) n_items += $urandom_range(0, d - 1);
            if (n_items == 0) n_items = 1;
         end
         base = $urandom;
         for (int k = 0; k < n_items; k++)
            send_sample(pick_value(base), k == n_items - 1, 0, 0);
         set_index++;
      end
      quiet = 1'b0;

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
